// ===== rtl/rbi_pkg.sv =====
// Shared types, register indexes and helpers for the ray versus box tester.
// No dependencies; every other file of the block imports this package.
package rbi_pkg;

  localparam int NAX = 3;
  localparam int DIV_STEPS = 31;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] dir_t;
  typedef logic signed [33:0] num_t;
  typedef logic [15:0] den_t;
  typedef logic signed [50:0] prod_t;

  typedef struct packed {
    logic hit;
    logic in_box;
    dir_t norm_x;
    dir_t norm_y;
    dir_t norm_z;
  } info_t;

  localparam logic [2:0] CFG_START_X = 3'd0;
  localparam logic [2:0] CFG_START_Y = 3'd1;
  localparam logic [2:0] CFG_START_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X   = 3'd3;
  localparam logic [2:0] CFG_DIR_Y   = 3'd4;
  localparam logic [2:0] CFG_DIR_Z   = 3'd5;
  localparam logic [2:0] CFG_LENGTH  = 3'd6;

  localparam dir_t NORM_POS = 16'sd16384;
  localparam dir_t NORM_NEG = -16'sd16384;
  localparam dir_t NORM_SAT = 16'sd32767;
  localparam dir_t DIR_MIN  = -16'sd32768;

  function automatic prod_t xmul(num_t n, den_t d);
    xmul = n * $signed({1'b0, d});
  endfunction

endpackage

// ===== rtl/ray_box_intersect_3d_core.sv =====
// Top level of the ray versus axis-aligned box tester: ray registers and
// the three pipeline parts. Uses rbi_pkg, rbi_slab, rbi_divsqrt, rbi_impact.
//
// The ray is held in seven registers written through the cfg port; the user
// must write them only while no box is in flight, which the block itself does
// not enforce. Boxes are taken one per clock cycle; busy never rises. Each box
// gives one result, shown for one cycle with done high, after six slab stages,
// one stage per quotient bit of the 31-bit parameter division, and two output stages.
// The receiver cannot stall, so results must be taken as they appear.
module ray_box_intersect_3d_core import rbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  coord_t       box_min_x,
  input  coord_t       box_min_y,
  input  coord_t       box_min_z,
  input  coord_t       box_max_x,
  input  coord_t       box_max_y,
  input  coord_t       box_max_z,
  output logic         done,
  output logic         hit,
  output coord_t       impact_x,
  output coord_t       impact_y,
  output coord_t       impact_z,
  output logic [30:0]  impact_dist,
  output dir_t         normal_x,
  output dir_t         normal_y,
  output dir_t         normal_z
);

  coord_t      ray_start [NAX];
  dir_t        ray_dir [NAX];
  logic [30:0] ray_length;
  logic [31:0] dsq [NAX];
  logic [31:0] msq;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_start[0] <= '0;
      ray_start[1] <= '0;
      ray_start[2] <= '0;
      ray_dir[0] <= NORM_POS;
      ray_dir[1] <= '0;
      ray_dir[2] <= '0;
      ray_length <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X: ray_start[0] <= cfg_data;
        CFG_START_Y: ray_start[1] <= cfg_data;
        CFG_START_Z: ray_start[2] <= cfg_data;
        CFG_DIR_X:   ray_dir[0] <= cfg_data[15:0];
        CFG_DIR_Y:   ray_dir[1] <= cfg_data[15:0];
        CFG_DIR_Z:   ray_dir[2] <= cfg_data[15:0];
        CFG_LENGTH:  ray_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NAX; a++) begin
      dsq[a] <= 32'(ray_dir[a] * ray_dir[a]);
    end
    msq <= dsq[0] + dsq[1] + dsq[2];
  end

  assign busy = 1'b0;

  coord_t box_min [NAX];
  coord_t box_max [NAX];
  assign box_min[0] = box_min_x;
  assign box_min[1] = box_min_y;
  assign box_min[2] = box_min_z;
  assign box_max[0] = box_max_x;
  assign box_max[1] = box_max_y;
  assign box_max[2] = box_max_z;

  logic        s_valid;
  info_t       s_info;
  logic [47:0] s_num;
  den_t        s_den;

  rbi_slab u_slab (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .box_min   (box_min),
    .box_max   (box_max),
    .start_pos (ray_start),
    .dir       (ray_dir),
    .len       (ray_length),
    .out_valid (s_valid),
    .out_info  (s_info),
    .num       (s_num),
    .den       (s_den)
  );

  logic        d_valid;
  info_t       d_info;
  logic [30:0] d_tl;
  logic [29:0] d_nrm;

  rbi_divsqrt u_divsqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_info   (s_info),
    .num       (s_num),
    .den       (s_den),
    .msq       (msq),
    .out_valid (d_valid),
    .out_info  (d_info),
    .tl        (d_tl),
    .nrm       (d_nrm)
  );

  coord_t impact [NAX];
  dir_t   normal [NAX];

  rbi_impact u_impact (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_info   (d_info),
    .tl        (d_tl),
    .nrm       (d_nrm),
    .start_pos (ray_start),
    .dir       (ray_dir),
    .done      (done),
    .hit       (hit),
    .impact    (impact),
    .distance  (impact_dist),
    .normal    (normal)
  );

  assign impact_x = impact[0];
  assign impact_y = impact[1];
  assign impact_z = impact[2];
  assign normal_x = normal[0];
  assign normal_y = normal[1];
  assign normal_z = normal[2];

endmodule

// ===== rtl/rbi_slab.sv =====
// Slab setup pipeline: bounds ordering, per-axis entry and exit fractions,
// their exact comparison, hit decision and face normal. Uses rbi_pkg.
module rbi_slab import rbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  coord_t       box_min [NAX],
  input  coord_t       box_max [NAX],
  input  coord_t       start_pos [NAX],
  input  dir_t         dir [NAX],
  input  logic [30:0]  len,
  output logic         out_valid,
  output info_t        out_info,
  output logic [47:0]  num,
  output den_t         den
);

  localparam int PA [3] = '{0, 0, 1};
  localparam int PB [3] = '{1, 2, 2};
  localparam int ORD [3] = '{2, 0, 1};

  // Stage A
  logic   va;
  coord_t lo [NAX];
  coord_t hi [NAX];

  always_ff @(posedge clk) begin
    va <= rst ? 1'b0 : in_valid;
    for (int a = 0; a < NAX; a++) begin
      lo[a] <= (box_min[a] < box_max[a]) ? box_min[a] : box_max[a];
      hi[a] <= (box_min[a] < box_max[a]) ? box_max[a] : box_min[a];
    end
  end

  // Stage B
  logic vb, insb, empb;
  num_t nlb [NAX];
  num_t nhb [NAX];
  num_t nrb [NAX];
  num_t frb [NAX];
  den_t ddb [NAX];
  logic [NAX-1:0] mvb;
  num_t nl_c [NAX];
  num_t nh_c [NAX];
  logic [NAX-1:0] mv_c, out_c;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      mv_c[a] = (dir[a] != 16'sd0) && (len != 31'd0);
      out_c[a] = (start_pos[a] < lo[a]) || (start_pos[a] > hi[a]);
      if (dir[a][15]) begin
        nl_c[a] = num_t'(start_pos[a]) - num_t'(lo[a]);
        nh_c[a] = num_t'(start_pos[a]) - num_t'(hi[a]);
      end else begin
        nl_c[a] = num_t'(lo[a]) - num_t'(start_pos[a]);
        nh_c[a] = num_t'(hi[a]) - num_t'(start_pos[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    vb <= rst ? 1'b0 : va;
    insb <= (out_c == '0);
    empb <= ((~mv_c & out_c) != '0);
    mvb <= mv_c;
    for (int a = 0; a < NAX; a++) begin
      nlb[a] <= nl_c[a];
      nhb[a] <= nh_c[a];
      nrb[a] <= (nl_c[a] <= nh_c[a]) ? nl_c[a] : nh_c[a];
      frb[a] <= (nl_c[a] <= nh_c[a]) ? nh_c[a] : nl_c[a];
      ddb[a] <= den_t'(dir[a][15] ? -dir[a] : dir[a]);
    end
  end

  // Stage C
  logic vc, insc, empc;
  num_t nlc [NAX];
  num_t nhc [NAX];
  num_t nrc [NAX];
  num_t frc [NAX];
  den_t ddc [NAX];
  logic [NAX-1:0] mvc;
  prod_t nab [3];
  prod_t nba [3];
  prod_t fab [3];
  prod_t fba [3];

  always_ff @(posedge clk) begin
    vc <= rst ? 1'b0 : vb;
    insc <= insb;
    empc <= empb;
    mvc <= mvb;
    nlc <= nlb;
    nhc <= nhb;
    nrc <= nrb;
    frc <= frb;
    ddc <= ddb;
    for (int p = 0; p < 3; p++) begin
      nab[p] <= xmul(nrb[PA[p]], ddb[PB[p]]);
      nba[p] <= xmul(nrb[PB[p]], ddb[PA[p]]);
      fab[p] <= xmul(frb[PA[p]], ddb[PB[p]]);
      fba[p] <= xmul(frb[PB[p]], ddb[PA[p]]);
    end
  end

  // Stage D
  logic ngt [NAX][NAX];
  logic fgt [NAX][NAX];
  logic [1:0] esel, fsel;
  logic anyc;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      for (int b = 0; b < NAX; b++) begin
        ngt[a][b] = 1'b0;
        fgt[a][b] = 1'b0;
      end
    end
    for (int p = 0; p < 3; p++) begin
      ngt[PA[p]][PB[p]] = nab[p] > nba[p];
      ngt[PB[p]][PA[p]] = nba[p] > nab[p];
      fgt[PA[p]][PB[p]] = fab[p] > fba[p];
      fgt[PB[p]][PA[p]] = fba[p] > fab[p];
    end
    esel = 2'd0;
    fsel = 2'd0;
    anyc = 1'b0;
    for (int a = 0; a < NAX; a++) begin
      if (mvc[a]) begin
        if (!anyc) begin
          esel = 2'(a);
          fsel = 2'(a);
          anyc = 1'b1;
        end else begin
          if (ngt[a][esel]) esel = 2'(a);
          if (fgt[fsel][a]) fsel = 2'(a);
        end
      end
    end
  end

  logic vd, insd, empd, anyd;
  num_t entn, extn;
  den_t entd, extd;
  num_t nld [NAX];
  num_t nhd [NAX];
  den_t ddd [NAX];
  logic [NAX-1:0] mvd;

  always_ff @(posedge clk) begin
    vd <= rst ? 1'b0 : vc;
    insd <= insc;
    empd <= empc;
    anyd <= anyc;
    mvd <= mvc;
    nld <= nlc;
    nhd <= nhc;
    ddd <= ddc;
    entn <= nrc[esel];
    entd <= ddc[esel];
    extn <= frc[fsel];
    extd <= ddc[fsel];
  end

  // Stage E
  logic ve, inse, empe, anye;
  logic [NAX-1:0] mve;
  num_t entn_e;
  den_t entd_e;
  prod_t pee, pxe, lhs;
  logic [46:0] rhs;
  prod_t pent [NAX];
  prod_t plo [NAX];
  prod_t phi [NAX];

  always_ff @(posedge clk) begin
    ve <= rst ? 1'b0 : vd;
    inse <= insd;
    empe <= empd;
    anye <= anyd;
    mve <= mvd;
    entn_e <= entn;
    entd_e <= entd;
    pee <= xmul(entn, extd);
    pxe <= xmul(extn, entd);
    lhs <= prod_t'(entn) <<< 14;
    rhs <= 47'(entd * len);
    for (int a = 0; a < NAX; a++) begin
      pent[a] <= xmul(entn, ddd[a]);
      plo[a] <= xmul(nld[a], entd);
      phi[a] <= xmul(nhd[a], entd);
    end
  end

  // Stage F
  logic slab, found;
  dir_t nrm [NAX];
  dir_t insn [NAX];
  info_t info_c;

  always_comb begin
    slab = anye && !empe && !(pee > pxe) && !entn_e[33] &&
           !(lhs > $signed({4'b0, rhs}));
    found = 1'b0;
    for (int a = 0; a < NAX; a++) begin
      nrm[a] = 16'sd0;
      insn[a] = (dir[a] == DIR_MIN) ? NORM_SAT : -dir[a];
    end
    for (int k = 0; k < NAX; k++) begin
      if (mve[ORD[k]] && !found) begin
        if (pent[ORD[k]] == plo[ORD[k]]) begin
          nrm[ORD[k]] = NORM_NEG;
          found = 1'b1;
        end else if (pent[ORD[k]] == phi[ORD[k]]) begin
          nrm[ORD[k]] = NORM_POS;
          found = 1'b1;
        end
      end
    end
    info_c.hit = inse | slab;
    info_c.in_box = inse;
    if (inse) begin
      info_c.norm_x = insn[0];
      info_c.norm_y = insn[1];
      info_c.norm_z = insn[2];
    end else if (slab) begin
      info_c.norm_x = nrm[0];
      info_c.norm_y = nrm[1];
      info_c.norm_z = nrm[2];
    end else begin
      info_c.norm_x = 16'sd0;
      info_c.norm_y = 16'sd0;
      info_c.norm_z = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : ve;
    out_info <= info_c;
    num <= {entn_e[33:0], 14'b0};
    den <= entd_e;
  end

endmodule

// ===== rtl/rbi_divsqrt.sv =====
// Bit-per-stage pipeline that computes the travelled parameter by long
// division and the direction norm by a digit square root. Uses rbi_pkg.
module rbi_divsqrt import rbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  info_t        in_info,
  input  logic [47:0]  num,
  input  den_t         den,
  input  logic [31:0]  msq,
  output logic         out_valid,
  output info_t        out_info,
  output logic [30:0]  tl,
  output logic [29:0]  nrm
);

  typedef struct packed {
    info_t       info;
    logic [16:0] rem;
    logic [30:0] nrest;
    den_t        dv;
    logic [30:0] quo;
    logic [33:0] srem;
    logic [61:0] vrest;
    logic [30:0] root;
  } ds_t;

  ds_t  st [DIV_STEPS+1];
  logic vld [DIV_STEPS+1];

  always_comb begin
    vld[0] = in_valid;
    st[0].info = in_info;
    st[0].rem = num[47:31];
    st[0].nrest = num[30:0];
    st[0].dv = den;
    st[0].quo = '0;
    st[0].srem = '0;
    st[0].vrest = {2'b0, msq, 28'b0};
    st[0].root = '0;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    ds_t nxt;
    logic [16:0] t;
    logic [33:0] s2, tr;

    always_comb begin
      nxt = st[g];
      t = {st[g].rem[15:0], st[g].nrest[30]};
      if (t >= {1'b0, st[g].dv}) begin
        nxt.rem = t - {1'b0, st[g].dv};
        nxt.quo = {st[g].quo[29:0], 1'b1};
      end else begin
        nxt.rem = t;
        nxt.quo = {st[g].quo[29:0], 1'b0};
      end
      nxt.nrest = {st[g].nrest[29:0], 1'b0};
      s2 = {st[g].srem[31:0], st[g].vrest[61:60]};
      tr = {1'b0, st[g].root, 2'b01};
      if (s2 >= tr) begin
        nxt.srem = s2 - tr;
        nxt.root = {st[g].root[29:0], 1'b1};
      end else begin
        nxt.srem = s2;
        nxt.root = {st[g].root[29:0], 1'b0};
      end
      nxt.vrest = {st[g].vrest[59:0], 2'b0};
    end

    always_ff @(posedge clk) begin
      vld[g+1] <= rst ? 1'b0 : vld[g];
      st[g+1] <= nxt;
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_info = st[DIV_STEPS].info;
  assign tl = st[DIV_STEPS].quo;
  assign nrm = st[DIV_STEPS].root[29:0];

endmodule

// ===== rtl/rbi_impact.sv =====
// Impact point and distance stages: scaling, rounding and saturation of the
// results, and the registered result ports. Uses rbi_pkg.
module rbi_impact import rbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  info_t        in_info,
  input  logic [30:0]  tl,
  input  logic [29:0]  nrm,
  input  coord_t       start_pos [NAX],
  input  dir_t         dir [NAX],
  output logic         done,
  output logic         hit,
  output coord_t       impact [NAX],
  output logic [30:0]  distance,
  output dir_t         normal [NAX]
);

  logic        vm;
  info_t       info_m;
  logic [46:0] mprod [NAX];
  logic [60:0] dprod;

  always_ff @(posedge clk) begin
    vm <= rst ? 1'b0 : in_valid;
    info_m <= in_info;
    dprod <= 61'(tl * nrm);
    for (int a = 0; a < NAX; a++) begin
      mprod[a] <= 47'(den_t'(dir[a][15] ? -dir[a] : dir[a]) * tl);
    end
  end

  logic [33:0] r [NAX];
  logic signed [34:0] sv [NAX];
  logic signed [34:0] sum [NAX];
  coord_t sat [NAX];
  logic [32:0] dr;
  logic [30:0] dsat;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      r[a] = 34'((mprod[a] + 47'd8192) >> 14);
      sv[a] = 35'(start_pos[a]);
      if (dir[a][15]) sum[a] = sv[a] - $signed({1'b0, r[a]});
      else sum[a] = sv[a] + $signed({1'b0, r[a]});
      if (sum[a] > 35'sd2147483647) sat[a] = 32'sh7fffffff;
      else if (sum[a] < -35'sd2147483648) sat[a] = 32'sh80000000;
      else sat[a] = sum[a][31:0];
    end
    dr = 33'((dprod + (61'd1 << 27)) >> 28);
    dsat = (dr > 33'h07fffffff) ? 31'h7fffffff : dr[30:0];
  end

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : vm;
    hit <= info_m.hit;
    normal[0] <= info_m.norm_x;
    normal[1] <= info_m.norm_y;
    normal[2] <= info_m.norm_z;
    for (int a = 0; a < NAX; a++) begin
      if (!info_m.hit) impact[a] <= '0;
      else if (info_m.in_box) impact[a] <= start_pos[a];
      else impact[a] <= sat[a];
    end
    if (!info_m.hit || info_m.in_box) distance <= '0;
    else distance <= dsat;
  end

endmodule

// ===== dv/tb_ray_box_intersect_3d_core.sv =====
// Self-checking testbench for ray_box_intersect_3d_core: a queue-fed driver,
// a result monitor and a slab-test predictor for the configured ray.
// Depends on rbi_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_ray_box_intersect_3d_core;
  import rbi_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ITEM_BOX, ITEM_CFG, ITEM_SYNC} item_kind_t;

  typedef struct packed {
    logic [2:0][31:0] mn;
    logic [2:0][31:0] mx;
  } box_t;

  typedef struct {
    item_kind_t  kind;
    box_t        box;
    logic [2:0]  idx;
    logic [31:0] data;
  } stim_t;

  typedef struct packed {
    logic        hit;
    coord_t      ix;
    coord_t      iy;
    coord_t      iz;
    logic [30:0] distance;
    dir_t        nx;
    dir_t        ny;
    dir_t        nz;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_START_X;
  logic [31:0] cfg_data = '0;
  coord_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
  coord_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic done, hit;
  coord_t impact_x, impact_y, impact_z;
  logic [30:0] impact_dist;
  dir_t normal_x, normal_y, normal_z;

  stim_t pending_q[$];
  hit_result_t expected_hits_q[$];
  logic [31:0] ray_reg [8];
  int gap_left = 0;
  int mismatches = 0;
  int boxes_sent = 0, hits_seen = 0, inside_seen = 0, cfg_writes = 0;

  // Planned ray, tracked while the stimulus is queued.
  longint plan_s [3];
  longint plan_d [3];
  longint plan_len;

  ray_box_intersect_3d_core u_top (
    .clk, .rst, .start, .busy, .cfg_we, .cfg_index, .cfg_data,
    .box_min_x, .box_min_y, .box_min_z, .box_max_x, .box_max_y, .box_max_z,
    .done, .hit, .impact_x, .impact_y, .impact_z, .impact_dist,
    .normal_x, .normal_y, .normal_z
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int cmp_frac(longint an, longint ad, longint bn, longint bd);
    longint l, r;
    l = an * bd;
    r = bn * ad;
    return (l > r) ? 1 : ((l < r) ? -1 : 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic coord_t sat_coord(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  function automatic hit_result_t slab_test(box_t b);
    longint s[3], d[3], lo[3], hi[3], tlo[3], thi[3], dd[3];
    longint len, en, ed, xn, xd, nrn, nrd, frn, frd, b0, b1, r;
    bit mv[3];
    bit any, empty, in_box;
    int a;
    int order[3];
    longint unsigned tl, msq, nrm, span, mag;
    hit_result_t res;
    dir_t nv[3];
    coord_t pt[3];
    res = '0;
    len = longint'(ray_reg[CFG_LENGTH][30:0]);
    any = 0; empty = 0; in_box = 1;
    en = 0; ed = 1; xn = 0; xd = 1;
    for (a = 0; a < 3; a++) begin
      b0 = longint'($signed(b.mn[a]));
      b1 = longint'($signed(b.mx[a]));
      s[a] = longint'($signed(ray_reg[a]));
      d[a] = longint'($signed(ray_reg[a + 3][15:0]));
      lo[a] = (b0 < b1) ? b0 : b1;
      hi[a] = (b0 < b1) ? b1 : b0;
      if (s[a] < lo[a] || s[a] > hi[a]) in_box = 0;
    end
    if (in_box) begin
      for (a = 0; a < 3; a++) begin
        r = -d[a];
        if (r > 32767) r = 32767;
        nv[a] = dir_t'(r);
        pt[a] = coord_t'(s[a]);
      end
      res.hit = 1'b1;
      {res.ix, res.iy, res.iz} = {pt[0], pt[1], pt[2]};
      {res.nx, res.ny, res.nz} = {nv[0], nv[1], nv[2]};
      return res;
    end
    for (a = 0; a < 3; a++) begin
      mv[a] = (d[a] != 0) && (len != 0);
      if (!mv[a]) begin
        if (s[a] < lo[a] || s[a] > hi[a]) empty = 1;
        continue;
      end
      dd[a] = (d[a] < 0) ? -d[a] : d[a];
      tlo[a] = (d[a] < 0) ? s[a] - lo[a] : lo[a] - s[a];
      thi[a] = (d[a] < 0) ? s[a] - hi[a] : hi[a] - s[a];
      if (tlo[a] <= thi[a]) begin
        nrn = tlo[a]; frn = thi[a];
      end else begin
        nrn = thi[a]; frn = tlo[a];
      end
      nrd = dd[a]; frd = dd[a];
      if (!any) begin
        en = nrn; ed = nrd; xn = frn; xd = frd; any = 1;
      end else begin
        if (cmp_frac(nrn, nrd, en, ed) > 0) begin en = nrn; ed = nrd; end
        if (cmp_frac(frn, frd, xn, xd) < 0) begin xn = frn; xd = frd; end
      end
    end
    if (!any || empty || cmp_frac(en, ed, xn, xd) > 0 || en < 0 || en * 16384 > ed * len)
      return res;
    res.hit = 1'b1;
    nv = '{16'sd0, 16'sd0, 16'sd0};
    order = '{2, 0, 1};
    for (int k = 0; k < 3; k++) begin
      a = order[k];
      if (!mv[a]) continue;
      if (cmp_frac(en, ed, tlo[a], dd[a]) == 0) begin
        nv[a] = NORM_NEG;
        break;
      end
      if (cmp_frac(en, ed, thi[a], dd[a]) == 0) begin
        nv[a] = NORM_POS;
        break;
      end
    end
    tl = longint'(en * 16384) / longint'(ed);
    if (tl > len) tl = len;
    msq = 0;
    for (a = 0; a < 3; a++) begin
      mag = (d[a] < 0) ? -d[a] : d[a];
      r = longint'((mag * tl + 8192) >> 14);
      pt[a] = sat_coord(s[a] + ((d[a] < 0) ? -r : r));
      msq += d[a] * d[a];
    end
    nrm = int_sqrt(msq << 28);
    span = (tl * nrm + (64'd1 << 27)) >> 28;
    if (span > 64'h7fffffff) span = 64'h7fffffff;
    res.distance = span[30:0];
    {res.ix, res.iy, res.iz} = {pt[0], pt[1], pt[2]};
    {res.nx, res.ny, res.nz} = {nv[0], nv[1], nv[2]};
    return res;
  endfunction

  // Driver: one transfer per box or register item, random gaps, register writes only when idle.
  always @(posedge clk) begin
    logic next_start;
    stim_t it;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      ray_reg = '{32'd0, 32'd0, 32'd0, 32'd16384, 32'd0, 32'd0, 32'd65536, 32'd0};
    end else begin
      if (cfg_we) begin
        if (cfg_index <= CFG_START_Z) ray_reg[cfg_index] = cfg_data;
        else if (cfg_index <= CFG_DIR_Z) ray_reg[cfg_index] = {16'd0, cfg_data[15:0]};
        else if (cfg_index == CFG_LENGTH) ray_reg[cfg_index] = {1'b0, cfg_data[30:0]};
      end
      next_start = start;
      if (start && !busy) begin
        expected_hits_q.push_back(slab_test({box_min_z, box_min_y, box_min_x,
                                             box_max_z, box_max_y, box_max_x}));
        boxes_sent++;
        next_start = 1'b0;
      end
      cfg_we <= 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!next_start && pending_q.size() > 0) begin
        it = pending_q[0];
        case (it.kind)
          ITEM_BOX: begin
            {box_min_z, box_min_y, box_min_x} <= {it.box.mn[2], it.box.mn[1], it.box.mn[0]};
            {box_max_z, box_max_y, box_max_x} <= {it.box.mx[2], it.box.mx[1], it.box.mx[0]};
            next_start = 1'b1;
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            void'(pending_q.pop_front());
          end
          ITEM_CFG: begin
            if (expected_hits_q.size() == 0) begin
              cfg_we <= 1'b1;
              cfg_index <= it.idx;
              cfg_data <= it.data;
              cfg_writes++;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (expected_hits_q.size() == 0) void'(pending_q.pop_front());
          end
        endcase
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    hit_result_t got, want;
    if (!rst && done) begin
      got = '{hit, impact_x, impact_y, impact_z, impact_dist, normal_x, normal_y, normal_z};
      if (expected_hits_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        want = expected_hits_q.pop_front();
        if (got.hit) hits_seen++;
        if (got.hit && got.distance == 0) inside_seen++;
        if (got.hit !== want.hit || got.ix !== want.ix || got.iy !== want.iy ||
            got.iz !== want.iz || got.distance !== want.distance || got.nx !== want.nx ||
            got.ny !== want.ny || got.nz !== want.nz) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic push_cfg(logic [2:0] idx, logic [31:0] data);
    stim_t it;
    it.kind = ITEM_CFG;
    it.idx = idx;
    it.data = data;
    it.box = '0;
    pending_q.push_back(it);
    if (idx <= CFG_START_Z) plan_s[idx] = longint'($signed(data));
    else if (idx <= CFG_DIR_Z) plan_d[idx - 3] = longint'($signed(data[15:0]));
    else if (idx == CFG_LENGTH) plan_len = longint'(data[30:0]);
  endtask

  task automatic set_ray(longint sx, longint sy, longint sz, longint dx, longint dy,
                         longint dz, longint len);
    push_cfg(CFG_START_X, sx[31:0]);
    push_cfg(CFG_START_Y, sy[31:0]);
    push_cfg(CFG_START_Z, sz[31:0]);
    push_cfg(CFG_DIR_X, dx[31:0]);
    push_cfg(CFG_DIR_Y, dy[31:0]);
    push_cfg(CFG_DIR_Z, dz[31:0]);
    push_cfg(CFG_LENGTH, len[31:0]);
  endtask

  task automatic push_box(longint x0, longint y0, longint z0, longint x1, longint y1,
                          longint z1);
    stim_t it;
    it.kind = ITEM_BOX;
    it.idx = CFG_START_X;
    it.data = '0;
    it.box.mn = {z0[31:0], y0[31:0], x0[31:0]};
    it.box.mx = {z1[31:0], y1[31:0], x1[31:0]};
    pending_q.push_back(it);
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Boxes placed around a random point of the planned ray, with some noise; about one in six is fully random.
  task automatic push_random_box();
    longint c[3], lo[3], hi[3], t, h, tmp;
    if ($urandom_range(0, 5) == 0) begin
      push_box($signed($urandom), $signed($urandom), $signed($urandom),
               $signed($urandom), $signed($urandom), $signed($urandom));
      return;
    end
    t = longint'($urandom_range(0, 32'h7fffffff)) % (plan_len + plan_len / 2 + 1)
        - plan_len / 4;
    for (int a = 0; a < 3; a++) begin
      c[a] = plan_s[a] + (plan_d[a] * t) / 16384;
      h = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
      lo[a] = clamp32(c[a] - h - longint'($urandom_range(0, 3)) * h / 2);
      hi[a] = clamp32(c[a] + h - longint'($urandom_range(0, 3)) * h / 2);
      if ($urandom_range(0, 7) == 0) begin
        tmp = lo[a]; lo[a] = hi[a]; hi[a] = tmp;
      end
    end
    push_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic push_sync();
    stim_t it;
    it.kind = ITEM_SYNC;
    it.idx = CFG_START_X;
    it.data = '0;
    it.box = '0;
    pending_q.push_back(it);
  endtask

  function automatic longint rand_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16384;
      2: return -16384;
      default: return longint'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  initial begin
    longint one;
    one = 65536;
    plan_s = '{0, 0, 0};
    plan_d = '{16384, 0, 0};
    plan_len = one;
    // Default ray: inside, face hits, beyond length, behind, swapped, empty slab.
    push_box(-one, -one, -one, one, one, one);
    push_box(one / 2, -one, -one, 2 * one, one, one);
    push_box(2 * one, -one, -one, 3 * one, one, one);
    push_box(-3 * one, -one, -one, -2 * one, one, one);
    push_box(2 * one, one, one, one / 4, -one, -one);
    push_box(one / 2, one, -one, 2 * one, 2 * one, one);
    push_box(one, 0, 0, one, 0, 0);
    push_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
             64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    push_box(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
             64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    push_sync();
    // Most negative direction from inside a box, then zero length.
    set_ray(0, 0, 0, -32768, -32768, -32768, 0);
    push_box(-one, -one, -one, one, one, one);
    push_box(one, -one, -one, 2 * one, one, one);
    push_cfg(CFG_UNUSED, 32'hffffffff);
    push_box(-one, -one, -one, one, one, one);
    // Diagonal ray of full length: saturating distance and far impacts.
    set_ray(64'sh80000000, 64'sh80000000, 64'sh80000000, 16384, 16384, 16384,
            64'sh7fffffff);
    push_box(0, 0, 0, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    push_box(64'sd1073741824, -64'sd2147483648, -64'sd2147483648,
             64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    set_ray(64'sd2147483647, 64'sd2147483647, 0, -16384, 0, 16384, 64'sh7fffffff);
    push_box(-64'sd2147483648, 0, one, 0, 64'sd2147483647, 2 * one);
    push_box(0, -one, -one, 64'sd2147483640, 64'sd2147483647, 64'sd2147483647);
    push_box(one, one, one, one, one, one);
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) begin
        set_ray(0, 0, 0, 16384, 0, 0, one);
      end else if (ph % 4 == 3) begin
        set_ray($signed($urandom), $signed($urandom), $signed($urandom),
                rand_dir(), rand_dir(), rand_dir(), $urandom_range(0, 32'h7fffffff));
      end else begin
        set_ray(longint'($signed($urandom)) >>> $urandom_range(8, 31),
                longint'($signed($urandom)) >>> $urandom_range(8, 31),
                longint'($signed($urandom)) >>> $urandom_range(8, 31),
                rand_dir(), rand_dir(), rand_dir(),
                $urandom_range(0, 1 << $urandom_range(0, 24)));
      end
      for (int i = 0; i < 82; i++) begin
        push_random_box();
        if (i == 40) push_sync();
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || start || expected_hits_q.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d boxes over %0d register writes; %0d hits, %0d at zero distance.",
             boxes_sent, cfg_writes, hits_seen, inside_seen);
    if (mismatches == 0 && expected_hits_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, expected_hits_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding.", expected_hits_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rbi_pkg.sv
rtl/rbi_slab.sv
rtl/rbi_divsqrt.sv
rtl/rbi_impact.sv
rtl/ray_box_intersect_3d_core.sv
dv/tb_ray_box_intersect_3d_core.sv
